/* hw/rtl/tpdp_pkg.sv */
package tpdp_pkg;

    // Field widths
    localparam int ACT_IDX_W = 12;
    localparam int ACT_W     = 8;
    localparam int WBYTE_W   = 8;
    localparam int K_W       = 13;
    localparam int SUM_OUT_W = 20;
    localparam int LANES     = 4;
    localparam int CODE_W    = 2;

    // Action codes
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_WEIGHT = 1'b1;

    // Ternary codes
    localparam logic [CODE_W-1:0] CODE_MASK = 2'h3;
    localparam logic [CODE_W-1:0] CODE_ADD  = 2'h1;
    localparam logic [CODE_W-1:0] CODE_SUB  = 2'h2;
    localparam logic [CODE_W-1:0] CODE_NONE = 2'h0;

    // Register map (register index is paddr[2])
    localparam logic REG_K_LENGTH = 1'b0;
    localparam logic [K_W-1:0] K_RESET = 13'd4096;

    // Output saturation bounds (21 bits covers the 20-bit range plus sign room)
    localparam int SAT_W = 21;
    localparam logic signed [SAT_W-1:0] SUM_MAX = 21'sd524287;
    localparam logic signed [SAT_W-1:0] SUM_MIN = -21'sd524288;

    // Front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Tree sum of four terms of +-128
    localparam int TREE_W = 11;

    // One operation handed from front to back
    typedef struct packed {
        logic                           clear;  // load: abandon column
        logic                           last;   // byte completes column
        logic [LANES-1:0][CODE_W-1:0]   codes;  // masked past k_length
        logic [LANES-1:0][ACT_W-1:0]    acts;
    } t_entry;

endpackage

/* hw/rtl/tpdp_ram.sv */
module tpdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tpdp_front.sv */
module tpdp_front #(
    parameter int MAX_K = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [tpdp_pkg::K_W-1:0]           i_k_length,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic                               i_action,
    input  logic [tpdp_pkg::ACT_IDX_W-1:0]     i_act_index,
    input  logic signed [tpdp_pkg::ACT_W-1:0]  i_act_value,
    input  logic [tpdp_pkg::WBYTE_W-1:0]       i_weight_byte,
    input  logic [tpdp_pkg::Q_AW:0]            i_q_level,
    output logic                               o_q_push,
    output tpdp_pkg::t_entry                   o_q_entry
);
    import tpdp_pkg::*;

    localparam int PW   = $clog2(MAX_K) + 1;
    localparam int CW   = (PW > K_W) ? PW : K_W;
    localparam int XW   = CW + 1;
    localparam int ROWS = (MAX_K + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                           accept;
    logic [XW-1:0]                  k_ext;
    logic [XW-1:0]                  max_k;
    logic [XW-1:0]                  k_eff;
    logic [XW-1:0]                  pos_ext;
    logic [XW-1:0]                  idx_ext;
    logic                           idx_ok;
    logic                           last;
    logic [LANES-1:0][CODE_W-1:0]   codes;
    logic [LANES-1:0][ACT_W-1:0]    rdata;
    logic [PW-1:0]                  r_pos;
    logic [PW-1:0]                  n_pos;
    logic                           r_a_valid;
    logic                           r_a_clear;
    logic                           r_a_last;
    logic [LANES-1:0][CODE_W-1:0]   r_a_codes;

    // Leave room in the queue for the word still waiting on the RAM read
    assign o_full = ({1'b0, i_q_level} + {{(Q_AW+1){1'b0}}, r_a_valid})
                    >= (Q_AW + 2)'(Q_DEPTH);
    assign accept = i_push && !o_full;

    // Clamp the length to 1..MAX_K
    assign k_ext   = {{(XW-K_W){1'b0}}, i_k_length};
    assign max_k   = XW'(MAX_K);
    assign k_eff   = (k_ext == '0) ? XW'(1) : ((k_ext > max_k) ? max_k : k_ext);
    assign pos_ext = {{(XW-PW){1'b0}}, r_pos};
    assign idx_ext = {{(XW-ACT_IDX_W){1'b0}}, i_act_index};
    assign idx_ok  = idx_ext < max_k;
    assign last    = (pos_ext + XW'(LANES)) >= k_eff;

    // Drop codes that fall past the end of the column
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if ((pos_ext + XW'(j)) < k_eff) begin
                codes[j] = i_weight_byte[CODE_W*j +: CODE_W];
            end else begin
                codes[j] = CODE_NONE;
            end
        end
    end

    // Advance the column position
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_action == ACTION_LOAD || last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + PW'(LANES);
            end
        end
    end

    // One bank per lane; a byte reads all four lanes of one row
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        tpdp_ram #(
            .WIDTH (ACT_W),
            .DEPTH (ROWS),
            .AW    (RW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (accept && i_action == ACTION_LOAD && idx_ok
                      && i_act_index[1:0] == 2'(b)),
            .i_waddr (idx_ext[RW+1:2]),
            .i_wdata (i_act_value),
            .i_re    (accept && i_action == ACTION_WEIGHT),
            .i_raddr (r_pos[RW+1:2]),
            .o_rdata (rdata[b])
        );
    end

    // Hold the classified word while the RAM read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_a_valid <= accept;
        end
        if (accept) begin
            r_a_clear <= (i_action == ACTION_LOAD);
            r_a_last  <= last;
            r_a_codes <= codes;
        end
    end

    assign o_q_push        = r_a_valid;
    assign o_q_entry.clear = r_a_clear;
    assign o_q_entry.last  = r_a_last;
    assign o_q_entry.codes = r_a_codes;
    assign o_q_entry.acts  = rdata;

endmodule

/* hw/rtl/tpdp_queue.sv */
module tpdp_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  tpdp_pkg::t_entry         i_entry,
    input  logic                     i_pop,
    output tpdp_pkg::t_entry         o_entry,
    output logic                     o_empty,
    output logic [tpdp_pkg::Q_AW:0]  o_level
);
    import tpdp_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_AW:0]     r_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // Store and advance pointers; the front never pushes into a full queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(do_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_level = r_count;

endmodule

/* hw/rtl/tpdp_back.sv */
module tpdp_back #(
    parameter int MAX_K = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tpdp_pkg::t_entry                       i_entry,
    input  logic                                   i_valid,
    output logic                                   o_take,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic signed [tpdp_pkg::SUM_OUT_W-1:0]  o_column_sum
);
    import tpdp_pkg::*;

    localparam int SW = $clog2(MAX_K) + ACT_W + 1;
    localparam int EW = (SW > SAT_W) ? SW : SAT_W;

    logic signed [SW-1:0]            r_sum;
    logic signed [SW-1:0]            n_sum;
    logic signed [SW-1:0]            sum_new;
    logic signed [EW-1:0]            sum_ext;
    logic signed [EW-1:0]            sum_sat;
    logic signed [TREE_W-1:0]        terms [LANES];
    logic signed [TREE_W-1:0]        tree;
    logic                            r_o_valid;
    logic signed [SUM_OUT_W-1:0]     r_o_sum;
    logic                            emit;

    // Map each code to +a, -a or nothing
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            unique case (i_entry.codes[j])
                CODE_ADD: terms[j] = TREE_W'($signed(i_entry.acts[j]));
                CODE_SUB: terms[j] = -TREE_W'($signed(i_entry.acts[j]));
                default:  terms[j] = '0;
            endcase
        end
    end

    assign tree    = (terms[0] + terms[1]) + (terms[2] + terms[3]);
    assign sum_new = r_sum + SW'(tree);
    assign sum_ext = EW'(sum_new);

    // Saturate to the 20-bit result range
    always_comb begin
        if (sum_ext > EW'(SUM_MAX)) begin
            sum_sat = EW'(SUM_MAX);
        end else if (sum_ext < EW'(SUM_MIN)) begin
            sum_sat = EW'(SUM_MIN);
        end else begin
            sum_sat = sum_ext;
        end
    end

    // Take a word unless it completes a column and the result slot is busy
    assign o_take = i_valid && (i_entry.clear || !i_entry.last || !r_o_valid || i_pop);
    assign emit   = o_take && !i_entry.clear && i_entry.last;

    always_comb begin
        n_sum = r_sum;
        if (o_take) begin
            if (i_entry.clear || i_entry.last) begin
                n_sum = '0;
            end else begin
                n_sum = sum_new;
            end
        end
    end

    // Accumulate and hold the finished column sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_sum <= n_sum;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_o_sum <= sum_sat[SUM_OUT_W-1:0];
        end
    end

    assign o_empty      = !r_o_valid;
    assign o_column_sum = r_o_sum;

endmodule

/* hw/rtl/ternary_packed_dot_product.sv */
// Ternary dot product of one stored signed 8-bit activation row with streamed
// weight columns. Load activations with action 0 (act_index, act_value); any
// load restarts the column. Then push packed weight bytes with action 1, four
// 2-bit codes each, lowest bits first (1 adds, 2 subtracts, 0 and 3 skip).
// The byte that reaches k_length (register 0, 1..MAX_K, reset 4096) yields one
// saturated 20-bit column_sum and starts the next column. Codes past k_length
// in the last byte are ignored. The block takes one word per clock while full
// is low: the row sits in four lane banks, so a byte reads its four
// activations in one RAM access, and a four-term add tree plus one accumulate
// finish it. A result passes the RAM read register, the queue and the result
// register. An activation must be loaded before any byte uses it.
// Write k_length only while the block is idle.
module ternary_packed_dot_product #(
    parameter int MAX_K = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input words
    input  logic                               push,
    output logic                               full,
    input  logic                               i_action,
    input  logic [tpdp_pkg::ACT_IDX_W-1:0]     i_act_index,
    input  logic signed [tpdp_pkg::ACT_W-1:0]  i_act_value,
    input  logic [tpdp_pkg::WBYTE_W-1:0]       i_weight_byte,
    // result words
    output logic                               empty,
    input  logic                               pop,
    output logic signed [tpdp_pkg::SUM_OUT_W-1:0] o_column_sum
);
    import tpdp_pkg::*;

    logic [K_W-1:0]   r_k_length;
    logic             q_push;
    t_entry           q_in;
    t_entry           q_head;
    logic             q_empty;
    logic [Q_AW:0]    q_level;
    logic             q_take;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_length <= K_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_K_LENGTH) begin
            r_k_length <= pwdata[K_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_K_LENGTH) ? {{(32-K_W){1'b0}}, r_k_length} : '0;

    tpdp_front #(
        .MAX_K (MAX_K)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_k_length    (r_k_length),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_act_index   (i_act_index),
        .i_act_value   (i_act_value),
        .i_weight_byte (i_weight_byte),
        .i_q_level     (q_level),
        .o_q_push      (q_push),
        .o_q_entry     (q_in)
    );

    tpdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_take),
        .o_entry (q_head),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    tpdp_back #(
        .MAX_K (MAX_K)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (q_head),
        .i_valid      (!q_empty),
        .o_take       (q_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_column_sum (o_column_sum)
    );

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpdp_pkg::*;

    localparam int ROW_DEPTH = 4096;
    localparam int ROW_FILL = 300;
    localparam int RUN_BUDGET = 30;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int SUM_HI = 524287;
    localparam int SUM_LO = -524288;
    localparam logic [2:0] K_LENGTH_ADDR = {REG_K_LENGTH, 2'b00};

    // Predicts column sums from the words the block accepts.
    class column_predictor;
        logic signed [ACT_W-1:0] row [ROW_DEPTH];
        logic [K_W-1:0] k_reg;
        int unsigned position;
        int running;
        logic signed [SUM_OUT_W-1:0] pending_sums [$];
        int errors;

        function new();
            k_reg = K_RESET;
            position = 0;
            running = 0;
            errors = 0;
        endfunction

        // Length as the block applies it: zero acts as one, clamp at the row depth.
        function int unsigned span();
            if (k_reg == 0) return 1;
            if (k_reg > ROW_DEPTH) return ROW_DEPTH;
            return k_reg;
        endfunction

        function void flag(string what, logic signed [31:0] want, logic signed [31:0] got);
            errors++;
            if (errors <= 10) $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        endfunction

        // Update the row or the column for one accepted word.
        function void take_word(logic action, logic [ACT_IDX_W-1:0] idx,
                                logic signed [ACT_W-1:0] val, logic [WBYTE_W-1:0] wb);
            int unsigned lim;
            int unsigned j;
            logic [CODE_W-1:0] code;
            lim = span();
            if (action == ACTION_LOAD) begin
                row[idx] = val;
                position = 0;
                running = 0;
                return;
            end
            for (j = 0; j < LANES; j++) begin
                code = wb[CODE_W*j +: CODE_W];
                if (position + j < lim) begin
                    if (code == CODE_ADD) running += int'(row[position + j]);
                    else if (code == CODE_SUB) running -= int'(row[position + j]);
                end
            end
            position += LANES;
            if (position >= lim) begin
                if (running > SUM_HI) running = SUM_HI;
                if (running < SUM_LO) running = SUM_LO;
                pending_sums.push_back(running[SUM_OUT_W-1:0]);
                position = 0;
                running = 0;
            end
        endfunction

        // Compare one popped sum against the oldest finished column not yet matched.
        function void match_sum(logic signed [SUM_OUT_W-1:0] got);
            logic signed [SUM_OUT_W-1:0] want;
            if (pending_sums.size() == 0) begin
                flag("column_sum with no column pending", 0, got);
                return;
            end
            want = pending_sums.pop_front();
            if (got !== want) flag("column_sum", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic i_action = ACTION_LOAD;
    logic [ACT_IDX_W-1:0] i_act_index = '0;
    logic signed [ACT_W-1:0] i_act_value = '0;
    logic [WBYTE_W-1:0] i_weight_byte = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [SUM_OUT_W-1:0] o_column_sum;

    column_predictor pred = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_off_reqs = 0;

    ternary_packed_dot_product dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_act_index  (i_act_index),
        .i_act_value  (i_act_value),
        .i_weight_byte(i_weight_byte),
        .empty        (empty),
        .pop          (pop),
        .o_column_sum (o_column_sum)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time.
    initial begin
        #4_000_000;
        $display("ternary_packed_dot_product test failed");
        $finish;
    end

    // Pop results with random stalls; hold off for a long stretch on request.
    initial begin : result_drain
        int hold_left;
        int hold_taken;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) pred.match_sum(o_column_sum);
            if (hold_off_reqs != hold_taken && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_taken = hold_off_reqs;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one word, idling first at random, and wait until it is taken.
    task automatic send_word(input logic action, input logic [ACT_IDX_W-1:0] idx,
                             input logic signed [ACT_W-1:0] val, input logic [WBYTE_W-1:0] wb);
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_action <= action;
        i_act_index <= idx;
        i_act_value <= val;
        i_weight_byte <= wb;
        do @(posedge i_clk); while (full);
        pred.take_word(action, idx, val, wb);
    endtask

    task automatic send_load(input logic [ACT_IDX_W-1:0] idx, input logic signed [ACT_W-1:0] val);
        send_word(ACTION_LOAD, idx, val, WBYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [WBYTE_W-1:0] wb);
        send_word(ACTION_WEIGHT, ACT_IDX_W'($urandom_range(0, ROW_DEPTH - 1)),
                  ACT_W'($urandom_range(0, 255)), wb);
    endtask

    // Drop push and wait until every expected sum has come, then let the pipe settle.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pred.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Read k_length back and compare with the predicted register.
    task automatic read_length();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= K_LENGTH_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32 - K_W){1'b0}}, pred.k_reg}) begin
            pred.flag("k_length read", pred.k_reg, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write k_length once the block is idle, then read it back.
    task automatic write_length(input logic [K_W-1:0] k);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= K_LENGTH_ADDR;
        pwdata <= {{(32 - K_W){1'b0}}, k};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pred.k_reg = k;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        read_length();
    endtask

    function automatic logic signed [ACT_W-1:0] pick_act();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -8'sd128;
        if (r == 1) return 8'sd127;
        return ACT_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [WBYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'h55;
        if (r == 1) return 8'hAA;
        return WBYTE_W'($urandom_range(0, 255));
    endfunction

    // Mostly whole columns with random content, some broken columns and stray bytes.
    task automatic run_columns(input int budget);
        int sent;
        int kind;
        int n;
        int i;
        int unsigned lim;
        sent = 0;
        while (sent < budget) begin
            lim = pred.span();
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        send_load(ACT_IDX_W'($urandom_range(0, lim - 1)), pick_act());
                    end else begin
                        send_load(ACT_IDX_W'($urandom_range(0, ROW_DEPTH - 1)), pick_act());
                    end
                end
                sent += n;
                n = (lim + LANES - 1) / LANES;
                for (i = 0; i < n; i++) send_byte(pick_byte());
                sent += n;
            end else if (kind < 90) begin
                n = $urandom_range(0, (lim + LANES - 1) / LANES - 1);
                for (i = 0; i < n; i++) send_byte(pick_byte());
                send_load(ACT_IDX_W'($urandom_range(0, ROW_DEPTH - 1)), pick_act());
                sent += n + 1;
            end else begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) send_byte(pick_byte());
                sent += n;
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int phase;
        int sub;
        int r;
        logic [K_W-1:0] k;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_length();

        // Fill the part of the row that columns read with the most negative value.
        for (i = 0; i < ROW_FILL; i++) send_load(ACT_IDX_W'(i), -8'sd128);

        // A length above the row depth reads back as written.
        write_length(13'd8191);

        // Length zero acts as one: only the lowest code counts.
        write_length(13'd0);
        send_load(12'd0, 8'sd127);
        send_load(12'd4095, 8'sd0);
        send_byte(8'hFD);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);

        // Tail codes of the last byte are ignored.
        write_length(13'd5);
        send_load(12'd1, -8'sd128);
        send_load(12'd2, 8'sd0);
        send_load(12'd3, 8'sd1);
        send_load(12'd4, -8'sd1);
        send_byte(8'h55);
        send_byte(8'hFE);

        // A load in the middle of a column abandons it.
        send_byte(8'h55);
        send_load(12'd2, -8'sd7);
        send_byte(8'h5A);
        send_byte(8'h01);

        // Shorten the length mid-column: the next byte closes it at once.
        write_length(13'd20);
        send_byte(8'h55);
        send_byte(8'h55);
        write_length(13'd5);
        send_byte(8'h55);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (phase = 0; phase < 4; phase++) begin
            for (sub = 0; sub < 4; sub++) begin
                r = $urandom_range(0, 99);
                if (r < 70) k = K_W'($urandom_range(1, 16));
                else if (r < 95) k = K_W'($urandom_range(17, 64));
                else k = K_W'($urandom_range(65, ROW_FILL));
                // Short columns make the long hold-off fill the block.
                if (phase == 0 && sub == 0) k = 13'd8;
                write_length(k);
                gap_pct = (phase == 1) ? 61 : (phase == 3) ? 29 : 0;
                stall_pct = (phase == 2) ? 61 : (phase == 3) ? 29 : 0;
                if (phase == 0 && sub == 0) hold_off_reqs++;
                run_columns(RUN_BUDGET);
                if (sub == 2) wait_drained();
                run_columns(RUN_BUDGET);
            end
        end
        write_length(K_RESET);

        wait_drained();
        if (pred.errors == 0) begin
            $display("ternary_packed_dot_product test passed");
        end else begin
            $display("ternary_packed_dot_product test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tpdp_pkg.sv
hw/rtl/tpdp_ram.sv
hw/rtl/tpdp_front.sv
hw/rtl/tpdp_queue.sv
hw/rtl/tpdp_back.sv
hw/rtl/ternary_packed_dot_product.sv
tb/tb.sv
